FILE: rtl/core/ewhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewhc_pkg: shared types and constants of the equal-width histogram
// Opcodes, result status codes, register indexes, field widths and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ewhc_pkg;

    // Field widths
    localparam int VAL_W     = 32;
    localparam int BIN_W     = 6;
    localparam int BINS_W    = 7;
    localparam int FRAC_W    = 17;
    localparam int STAT_W    = 3;
    localparam int OP_W      = 2;
    localparam int CFG_AW    = 2;
    localparam int TDATA_W   = 184;
    localparam int DIV_W     = 32;
    localparam int STEP_W    = 6;

    // Opcodes
    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_READOUT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_COUNTED   = 3'd0;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_READOUT   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_CLEARED   = 3'd4;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_LOWER = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_UPPER = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_BINS  = 2'd2;

    // Register reset values
    localparam logic [VAL_W-1:0]  LOWER_RST = 32'd0;
    localparam logic [VAL_W-1:0]  UPPER_RST = 32'd1048576;
    localparam logic [BINS_W-1:0] BINS_RST  = 7'd16;

    // Fraction value of one in Q1.16
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // Divider step counts for the three quotients
    localparam logic [STEP_W-1:0] BIN_STEPS  = 6'd6;
    localparam logic [STEP_W-1:0] FRAC_STEPS = 6'd16;
    localparam logic [STEP_W-1:0] EDGE_STEPS = 6'd32;

    // Controller to datapath commands
    typedef struct packed {
        logic                capture;
        logic                classify;
        logic                bdiv_go;
        logic                bin_take;
        logic                bin_upd;
        logic                rd_init;
        logic                rd_acc;
        logic                frac_go;
        logic                frac_take;
        logic                edge_mul;
        logic                ediv_go;
        logic                edge_take;
        logic                clear;
        logic                emit;
        logic                next_bin;
        logic [STAT_W-1:0]   status;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic under;
        logic over;
        logic frac_div;
        logic div_done;
        logic div_busy;
        logic out_free;
        logic last_bin;
    } t_stat;

endpackage

FILE: rtl/core/equal_width_histogram_cdf_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equal_width_histogram_cdf_top: equal-width histogram with cumulative readout
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata sample, tuser opcode
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata bin fields, tuser
//                                                status, tlast last word
//   cfg       in   i_cfg_we                      i_cfg_addr, i_cfg_wdata
//
// One input word at a time. A sample in range uses the shared radix-2
// divider twice (6 steps for the bin, 32 for its lower edge); a sample out
// of range or a clear needs no divide. A readout divides for each bin's
// fraction, unless the bin needs no fraction divide, and for its lower edge.
// Reset is synchronous, active low, and empties all counters at once through
// per-bin valid bits. A word waits in the output register; m_axis_tready low stalls the next one.
// ----------------------------------------------------------------------------
module equal_width_histogram_cdf_top
    import ewhc_pkg::*;
#(
    parameter int MAX_BINS     = 64,
    parameter int COUNTER_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [VAL_W-1:0]     s_axis_tdata,   // [31:0] sample_value
    input  logic [OP_W-1:0]      s_axis_tuser,   // [1:0] opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [5:0] bin_index, [37:6] bin_count, [54:38] cumulative_fraction,
    // [86:55] bin_lower_edge, [118:87] entries_total,
    // [150:119] underflow_total, [182:151] overflow_total, [183] zero
    output logic [TDATA_W-1:0]   m_axis_tdata,
    output logic [STAT_W-1:0]    m_axis_tuser,   // [2:0] status
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [VAL_W-1:0]     i_cfg_wdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    ewhc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ewhc_dp #(
        .MAX_BINS     (MAX_BINS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_sample    (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast)
    );

`ifndef ASSERT_OFF
    // A word is loaded only into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_stat.out_free)
        else $error("word loaded over an undelivered word");

    // No input word is taken while a divide is running
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_stat.div_busy)
        else $error("input ready while divider busy");

    // Only readout words can be non-final
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_READOUT)) |-> m_axis_tlast)
        else $error("single-word result without last");

    // Cumulative fraction never exceeds one
    a_frac_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[54:38] <= FRAC_ONE))
        else $error("cumulative fraction above one");
`endif

endmodule

FILE: rtl/core/ewhc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewhc_div: radix-2 restoring divider
// Produces one quotient bit per cycle. The caller splits the dividend into
// a starting remainder (below the divisor) and the low bits still to shift
// in, left aligned, and gives the number of steps.
// ----------------------------------------------------------------------------
module ewhc_div
    import ewhc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_rem,
    input  logic [DIV_W-1:0]  i_low,
    input  logic [DIV_W-1:0]  i_divisor,
    input  logic [STEP_W-1:0] i_steps,
    output logic [DIV_W-1:0]  o_quot,
    output logic              o_busy,
    output logic              o_done
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_low;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_W-1:0]  r_quot;

    logic [DIV_W:0]    w_trial;
    logic [DIV_W:0]    w_diff;
    logic              w_ge;
    logic [DIV_W-1:0]  n_rem;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_low[DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
        n_rem   = w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
    end

    // Step count and handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder, dividend bits and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_low  <= i_low;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_low  <= {r_low[DIV_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_W-2:0], w_ge};
        end
    end

    assign o_quot = r_quot;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

FILE: rtl/core/ewhc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewhc_dp: histogram datapath
// Range registers, bin counter memory, totals, the product register, the
// shared divider and the output word register.
// ----------------------------------------------------------------------------
module ewhc_dp
    import ewhc_pkg::*;
#(
    parameter int MAX_BINS     = 64,
    parameter int COUNTER_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [VAL_W-1:0]      i_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [VAL_W-1:0]      i_cfg_wdata,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [TDATA_W-1:0]    o_tdata,
    output logic [STAT_W-1:0]     o_tuser,
    output logic                  o_tlast
);

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CUM_W = COUNTER_BITS + BIN_W;
    localparam int PROD_W = VAL_W + BIN_W;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    // Range registers
    logic signed [VAL_W-1:0] r_lower;
    logic signed [VAL_W-1:0] r_upper;
    logic [BINS_W-1:0]       r_bins;

    // Item and working registers
    logic signed [VAL_W-1:0] r_sample;
    logic [BIN_W-1:0]        r_k;
    logic [PROD_W-1:0]       r_prod;
    logic [CUM_W-1:0]        r_cum;
    logic [COUNTER_BITS-1:0] r_cnt;
    logic [FRAC_W-1:0]       r_frac;
    logic [VAL_W-1:0]        r_edge;

    // Totals
    logic [COUNTER_BITS-1:0] r_entries;
    logic [COUNTER_BITS-1:0] r_under;
    logic [COUNTER_BITS-1:0] r_over;

    // Bin counter memory
    logic [COUNTER_BITS-1:0] r_mem [MAX_BINS];
    logic [MAX_BINS-1:0]     r_valid;
    logic [COUNTER_BITS-1:0] r_rdata;
    logic                    r_rvalid;

    // Output word
    logic                    r_out_valid;
    logic [BIN_W-1:0]        r_o_idx;
    logic [STAT_W-1:0]       r_o_stat;
    logic [VAL_W-1:0]        r_o_cnt;
    logic [FRAC_W-1:0]       r_o_frac;
    logic [VAL_W-1:0]        r_o_edge;
    logic [VAL_W-1:0]        r_o_entries;
    logic [VAL_W-1:0]        r_o_under;
    logic [VAL_W-1:0]        r_o_over;
    logic                    r_o_last;

    logic [BINS_W-1:0]       w_n;
    logic [BINS_W-1:0]       w_nm1;
    logic [VAL_W:0]          w_diff;
    logic [VAL_W-1:0]        w_span;
    logic [VAL_W:0]          w_off;
    logic                    w_under;
    logic                    w_over;
    logic [PROD_W-1:0]       w_bprod;
    logic [PROD_W-1:0]       w_eprod;
    logic [IDX_W-1:0]        w_addr;
    logic [COUNTER_BITS-1:0] w_rd_cnt;
    logic [COUNTER_BITS-1:0] w_binc;
    logic                    w_frac_div;
    logic                    w_last_bin;
    logic                    w_out_free;
    logic                    w_keep;
    logic [BIN_W-1:0]        w_take;

    logic                    w_div_start;
    logic [DIV_W-1:0]        w_div_rem;
    logic [DIV_W-1:0]        w_div_low;
    logic [DIV_W-1:0]        w_div_den;
    logic [STEP_W-1:0]       w_div_steps;
    logic [DIV_W-1:0]        w_quot;
    logic                    w_div_busy;
    logic                    w_div_done;

    // Bin count in use, range span and sample offset
    always_comb begin
        if (r_bins == '0) begin
            w_n = BINS_W'(1);
        end else if (r_bins > BINS_W'(MAX_BINS)) begin
            w_n = BINS_W'(MAX_BINS);
        end else begin
            w_n = r_bins;
        end
        w_nm1  = w_n - BINS_W'(1);
        w_diff = {r_upper[VAL_W-1], r_upper} - {r_lower[VAL_W-1], r_lower};
        w_span = w_diff[VAL_W] ? (~w_diff[VAL_W-1:0] + VAL_W'(1)) : w_diff[VAL_W-1:0];
        w_off  = {r_sample[VAL_W-1], r_sample} - {r_lower[VAL_W-1], r_lower};
        w_under = (r_sample < r_lower);
        w_over  = (r_sample >= r_upper);
    end

    // Products: offset times bins, and bin times span plus rounding term
    assign w_bprod = w_off[VAL_W-1:0] * w_n;
    assign w_eprod = r_k * w_span + PROD_W'(w_nm1);

    // Counter read, increment with saturation
    assign w_addr   = r_k[IDX_W-1:0];
    assign w_rd_cnt = r_rvalid ? r_rdata : '0;
    assign w_binc   = (w_rd_cnt == CNT_MAX) ? CNT_MAX : w_rd_cnt + COUNTER_BITS'(1);

    assign w_frac_div = (r_entries != '0) && (r_cum < CUM_W'(r_entries));
    assign w_last_bin = ({1'b0, r_k} == w_nm1);
    assign w_out_free = !r_out_valid || i_tready;
    assign w_take     = ({1'b0, w_quot[BIN_W-1:0]} > w_nm1) ? w_nm1[BIN_W-1:0]
                                                           : w_quot[BIN_W-1:0];

    // Divider operand selection
    always_comb begin
        w_div_start = i_cmd.bdiv_go || i_cmd.ediv_go || (i_cmd.frac_go && w_frac_div);
        if (i_cmd.bdiv_go) begin
            w_div_rem   = r_prod[PROD_W-1:BIN_W];
            w_div_low   = {r_prod[BIN_W-1:0], {(DIV_W-BIN_W){1'b0}}};
            w_div_den   = w_span;
            w_div_steps = BIN_STEPS;
        end else if (i_cmd.ediv_go) begin
            w_div_rem   = DIV_W'(r_prod[PROD_W-1:VAL_W]);
            w_div_low   = r_prod[VAL_W-1:0];
            w_div_den   = DIV_W'(w_n);
            w_div_steps = EDGE_STEPS;
        end else begin
            w_div_rem   = DIV_W'(r_cum);
            w_div_low   = '0;
            w_div_den   = DIV_W'(r_entries);
            w_div_steps = FRAC_STEPS;
        end
    end

    ewhc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_rem     (w_div_rem),
        .i_low     (w_div_low),
        .i_divisor (w_div_den),
        .i_steps   (w_div_steps),
        .o_quot    (w_quot),
        .o_busy    (w_div_busy),
        .o_done    (w_div_done)
    );

    // Range registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= LOWER_RST;
            r_upper <= UPPER_RST;
            r_bins  <= BINS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_LOWER: r_lower <= i_cfg_wdata;
                CFG_UPPER: r_upper <= i_cfg_wdata;
                CFG_BINS:  r_bins  <= i_cfg_wdata[BINS_W-1:0];
                default: ;
            endcase
        end
    end

    // Totals and valid bits of the counter memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
            r_under   <= '0;
            r_over    <= '0;
            r_valid   <= '0;
        end else if (i_cmd.clear) begin
            r_entries <= '0;
            r_under   <= '0;
            r_over    <= '0;
            r_valid   <= '0;
        end else begin
            if (i_cmd.classify) begin
                if (w_under) begin
                    r_under <= (r_under == CNT_MAX) ? CNT_MAX : r_under + COUNTER_BITS'(1);
                end else if (w_over) begin
                    r_over <= (r_over == CNT_MAX) ? CNT_MAX : r_over + COUNTER_BITS'(1);
                end
            end
            if (i_cmd.bin_upd) begin
                r_entries <= (r_entries == CNT_MAX) ? CNT_MAX
                                                    : r_entries + COUNTER_BITS'(1);
                r_valid[w_addr] <= 1'b1;
            end
        end
    end

    // Counter memory: one write port, registered read at the current bin
    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_upd) begin
            r_mem[w_addr] <= w_binc;
        end
        r_rdata  <= r_mem[w_addr];
        r_rvalid <= r_valid[w_addr];
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
        if (i_cmd.classify) begin
            r_prod <= w_bprod;
        end else if (i_cmd.edge_mul) begin
            r_prod <= w_eprod;
        end
        if (i_cmd.rd_init) begin
            r_k <= '0;
        end else if (i_cmd.bin_take) begin
            r_k <= w_take;
        end else if (i_cmd.next_bin) begin
            r_k <= r_k + BIN_W'(1);
        end
        if (i_cmd.rd_init) begin
            r_cum <= '0;
        end else if (i_cmd.rd_acc) begin
            r_cum <= r_cum + CUM_W'(w_rd_cnt);
        end
        if (i_cmd.bin_upd) begin
            r_cnt <= w_binc;
        end else if (i_cmd.rd_acc) begin
            r_cnt <= w_rd_cnt;
        end
        if (i_cmd.frac_go && !w_frac_div) begin
            r_frac <= (r_entries == '0) ? '0 : FRAC_ONE;
        end else if (i_cmd.frac_take) begin
            r_frac <= {1'b0, w_quot[FRAC_W-2:0]};
        end
        if (i_cmd.edge_take) begin
            r_edge <= r_lower + w_quot;
        end
    end

    // Output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload; only counted and readout words carry bin fields
    assign w_keep = (i_cmd.status == STAT_COUNTED) || (i_cmd.status == STAT_READOUT);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_idx     <= w_keep ? r_k : '0;
            r_o_stat    <= i_cmd.status;
            r_o_cnt     <= w_keep ? VAL_W'(r_cnt) : '0;
            r_o_frac    <= (i_cmd.status == STAT_READOUT) ? r_frac : '0;
            r_o_edge    <= w_keep ? r_edge : '0;
            r_o_entries <= VAL_W'(r_entries);
            r_o_under   <= VAL_W'(r_under);
            r_o_over    <= VAL_W'(r_over);
            r_o_last    <= (i_cmd.status != STAT_READOUT) || w_last_bin;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {1'b0, r_o_over, r_o_under, r_o_entries, r_o_edge,
                       r_o_frac, r_o_cnt, r_o_idx};
    assign o_tuser  = r_o_stat;
    assign o_tlast  = r_o_last;

    // Status to the controller
    always_comb begin
        o_stat.under    = w_under;
        o_stat.over     = w_over;
        o_stat.frac_div = w_frac_div;
        o_stat.div_done = w_div_done;
        o_stat.div_busy = w_div_busy;
        o_stat.out_free = w_out_free;
        o_stat.last_bin = w_last_bin;
    end

endmodule

FILE: rtl/core/ewhc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ewhc_ctrl: histogram sequencer
// Takes one input word at a time and steps the datapath through classify,
// bin divide, counter update, fraction and edge divides and word output.
// ----------------------------------------------------------------------------
module ewhc_ctrl
    import ewhc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic [OP_W-1:0] i_opcode,
    output logic            o_s_tready,
    input  t_stat           i_stat,
    output t_cmd            o_cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CLASS     = 4'd1;
    localparam logic [3:0] ST_BDIV_GO   = 4'd2;
    localparam logic [3:0] ST_BDIV_WAIT = 4'd3;
    localparam logic [3:0] ST_BIN_RD    = 4'd4;
    localparam logic [3:0] ST_BIN_UPD   = 4'd5;
    localparam logic [3:0] ST_RD_RD     = 4'd6;
    localparam logic [3:0] ST_RD_ACC    = 4'd7;
    localparam logic [3:0] ST_FRAC      = 4'd8;
    localparam logic [3:0] ST_FRAC_WAIT = 4'd9;
    localparam logic [3:0] ST_EDGE_MUL  = 4'd10;
    localparam logic [3:0] ST_EDGE_GO   = 4'd11;
    localparam logic [3:0] ST_EDGE_WAIT = 4'd12;
    localparam logic [3:0] ST_EMIT      = 4'd13;

    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_status <= STAT_COUNTED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_cmd        = '0;
        o_cmd.status = r_status;
        o_s_tready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_opcode)
                        OP_SAMPLE: begin
                            n_state = ST_CLASS;
                        end
                        OP_READOUT: begin
                            o_cmd.rd_init = 1'b1;
                            n_status      = STAT_READOUT;
                            n_state       = ST_RD_RD;
                        end
                        OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                            n_status    = STAT_CLEARED;
                            n_state     = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            // Sort the sample against the range
            ST_CLASS: begin
                o_cmd.classify = 1'b1;
                if (i_stat.under) begin
                    n_status = STAT_UNDERFLOW;
                    n_state  = ST_EMIT;
                end else if (i_stat.over) begin
                    n_status = STAT_OVERFLOW;
                    n_state  = ST_EMIT;
                end else begin
                    n_status = STAT_COUNTED;
                    n_state  = ST_BDIV_GO;
                end
            end
            ST_BDIV_GO: begin
                o_cmd.bdiv_go = 1'b1;
                n_state       = ST_BDIV_WAIT;
            end
            ST_BDIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.bin_take = 1'b1;
                    n_state        = ST_BIN_RD;
                end
            end
            ST_BIN_RD: begin
                n_state = ST_BIN_UPD;
            end
            ST_BIN_UPD: begin
                o_cmd.bin_upd = 1'b1;
                n_state       = ST_EDGE_MUL;
            end
            // Readout: fetch a bin and accumulate
            ST_RD_RD: begin
                n_state = ST_RD_ACC;
            end
            ST_RD_ACC: begin
                o_cmd.rd_acc = 1'b1;
                n_state      = ST_FRAC;
            end
            ST_FRAC: begin
                o_cmd.frac_go = 1'b1;
                n_state       = i_stat.frac_div ? ST_FRAC_WAIT : ST_EDGE_MUL;
            end
            ST_FRAC_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.frac_take = 1'b1;
                    n_state         = ST_EDGE_MUL;
                end
            end
            // Lower edge of the current bin
            ST_EDGE_MUL: begin
                o_cmd.edge_mul = 1'b1;
                n_state        = ST_EDGE_GO;
            end
            ST_EDGE_GO: begin
                o_cmd.ediv_go = 1'b1;
                n_state       = ST_EDGE_WAIT;
            end
            ST_EDGE_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.edge_take = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            // Hand the word to the output register, advance on readout
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if ((r_status == STAT_READOUT) && !i_stat.last_bin) begin
                        o_cmd.next_bin = 1'b1;
                        n_state        = ST_RD_RD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
